// ----- hw/rtl/rpnalu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack ALU package
// Shared widths, command and status codes, and the controller/datapath
// interface structs.
// ----------------------------------------------------------------------------
package rpnalu_pkg;

    localparam int DATA_W          = 32;
    localparam int CMD_W           = 3;
    localparam int STAT_W          = 2;
    localparam int HELD_W          = 4;
    localparam int DEF_STACK_DEPTH = 10;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUL   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIV   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_POP   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd6;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FEW  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_DIV0 = 2'd3;

    // write-back source for two-operand commands
    localparam int ALU_SEL_W = 3;
    localparam logic [ALU_SEL_W-1:0] ALU_ADD  = 3'd0;
    localparam logic [ALU_SEL_W-1:0] ALU_SUB  = 3'd1;
    localparam logic [ALU_SEL_W-1:0] ALU_MUL  = 3'd2;
    localparam logic [ALU_SEL_W-1:0] ALU_DIV  = 3'd3;
    localparam logic [ALU_SEL_W-1:0] ALU_ZERO = 3'd4;

    typedef struct packed {
        logic                  load;      // capture transaction, read top two
        logic                  decode;    // latch status and popped value
        logic                  push;
        logic                  pop;
        logic                  clear;
        logic                  alu_wr;    // write result over second, drop top
        logic [ALU_SEL_W-1:0]  alu_sel;
        logic                  mul_cap;
        logic                  div_start;
        logic [STAT_W-1:0]     st;
        logic                  out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             empty;
        logic             few;
        logic             full;
        logic             b_zero;
        logic             div_done;
        logic             out_free;
    } dp_sts_t;

endpackage

// ----- hw/rtl/rpnalu_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN ALU divider
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle,
// quotient truncated toward zero and wrapped to 32 bits.
// ----------------------------------------------------------------------------
module rpnalu_div
    import rpnalu_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] dividend,
    input  logic signed [DATA_W-1:0] divisor,
    output logic                     done,
    output logic signed [DATA_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   diff;

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        rem_sh    = {rem_reg, quo_reg[DATA_W-1]};
        diff      = rem_sh - {1'b0, dvs_reg};
        if (start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            neg_next  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            rem_next  = '0;
            quo_next  = dividend[DATA_W-1] ? DATA_W'(0) - DATA_W'(dividend) : DATA_W'(dividend);
            dvs_next  = divisor[DATA_W-1] ? DATA_W'(0) - DATA_W'(divisor) : DATA_W'(divisor);
        end else if (busy_reg) begin
            if (!diff[DATA_W]) begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        neg_reg <= neg_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? $signed(DATA_W'(0) - quo_reg) : $signed(quo_reg);

endmodule

// ----- hw/rtl/rpnalu_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN ALU datapath
// Stack memory, entry counter, operand registers, multiplier, divider and
// the result output register.
// ----------------------------------------------------------------------------
module rpnalu_dp
    import rpnalu_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [CMD_W-1:0]         s_cmd,
    input  logic signed [DATA_W-1:0] s_push_value,
    input  ctrl_cmd_t                ctrl,
    output dp_sts_t                  sts,
    input  logic                     m_ready,
    output logic                     m_valid,
    output logic signed [DATA_W-1:0] m_popped_value,
    output logic [STAT_W-1:0]        m_status,
    output logic [HELD_W-1:0]        m_entries_held
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic signed [DATA_W-1:0] stack_mem [STACK_DEPTH];

    logic [CMD_W-1:0]         cmd_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic [CW-1:0]            count_reg, count_next;
    logic signed [DATA_W-1:0] rd_a_reg, rd_b_reg;
    logic signed [DATA_W-1:0] prod_reg;
    logic signed [DATA_W-1:0] pop_reg;
    logic [STAT_W-1:0]        stat_reg;
    logic                     m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] m_popped_value_reg;
    logic [STAT_W-1:0]        m_status_reg;
    logic [HELD_W-1:0]        m_entries_held_reg;

    logic [AW-1:0]            rd_addr_a, rd_addr_b, wr_addr;
    logic                     wr_en;
    logic signed [DATA_W-1:0] wr_data;
    logic                     div_done;
    logic signed [DATA_W-1:0] div_quo;

    // keep addresses in range while the stack holds fewer than two entries
    assign rd_addr_b = (count_reg == '0) ? '0 : AW'(count_reg - CW'(1));
    assign rd_addr_a = (count_reg < CW'(2)) ? '0 : AW'(count_reg - CW'(2));

    always_comb begin
        wr_en   = ctrl.push | ctrl.alu_wr;
        wr_addr = ctrl.push ? AW'(count_reg) : rd_addr_a;
        case (ctrl.alu_sel)
            ALU_ADD:  wr_data = rd_a_reg + rd_b_reg;
            ALU_SUB:  wr_data = rd_a_reg - rd_b_reg;
            ALU_MUL:  wr_data = prod_reg;
            ALU_DIV:  wr_data = div_quo;
            default:  wr_data = '0;
        endcase
        if (ctrl.push) begin
            wr_data = val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (ctrl.load) begin
            rd_a_reg <= stack_mem[rd_addr_a];
            rd_b_reg <= stack_mem[rd_addr_b];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ctrl.clear) begin
            count_next = '0;
        end else if (ctrl.push) begin
            count_next = count_reg + CW'(1);
        end else if (ctrl.pop || ctrl.alu_wr) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctrl.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        if (ctrl.load) begin
            cmd_reg <= s_cmd;
            val_reg <= s_push_value;
        end
        if (ctrl.mul_cap) begin
            prod_reg <= DATA_W'(rd_a_reg * rd_b_reg);
        end
        if (ctrl.decode) begin
            stat_reg <= ctrl.st;
            pop_reg  <= ctrl.pop ? rd_b_reg : '0;
        end
        if (ctrl.out_load) begin
            m_popped_value_reg <= pop_reg;
            m_status_reg       <= stat_reg;
            m_entries_held_reg <= HELD_W'(count_reg);
        end
    end

    rpnalu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctrl.div_start),
        .dividend (rd_a_reg),
        .divisor  (rd_b_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        sts.cmd      = cmd_reg;
        sts.empty    = (count_reg == '0);
        sts.few      = (count_reg < CW'(2));
        sts.full     = (count_reg == CW'(STACK_DEPTH));
        sts.b_zero   = (rd_b_reg == '0);
        sts.div_done = div_done;
        sts.out_free = !m_valid_reg || m_ready;
    end

    assign m_valid        = m_valid_reg;
    assign m_popped_value = m_popped_value_reg;
    assign m_status       = m_status_reg;
    assign m_entries_held = m_entries_held_reg;

endmodule

// ----- hw/rtl/rpnalu_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN ALU controller
// Sequences one command: capture, decode, optional multiply or divide,
// write-back and hand-off to the output register.
// ----------------------------------------------------------------------------
module rpnalu_ctrl
    import rpnalu_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  dp_sts_t   sts,
    output ctrl_cmd_t ctrl
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        ctrl.st    = STAT_OK;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ctrl.load  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                ctrl.decode = 1'b1;
                state_next  = S_DONE;
                case (sts.cmd)
                    CMD_PUSH: begin
                        if (sts.full) begin
                            ctrl.st = STAT_FULL;
                        end else begin
                            ctrl.push = 1'b1;
                        end
                    end
                    CMD_ADD, CMD_SUB: begin
                        if (sts.few) begin
                            ctrl.st = STAT_FEW;
                        end else begin
                            ctrl.alu_wr  = 1'b1;
                            ctrl.alu_sel = (sts.cmd == CMD_ADD) ? ALU_ADD : ALU_SUB;
                        end
                    end
                    CMD_MUL: begin
                        if (sts.few) begin
                            ctrl.st = STAT_FEW;
                        end else begin
                            ctrl.mul_cap = 1'b1;
                            state_next   = S_MUL;
                        end
                    end
                    CMD_DIV: begin
                        if (sts.few) begin
                            ctrl.st = STAT_FEW;
                        end else if (sts.b_zero) begin
                            ctrl.st      = STAT_DIV0;
                            ctrl.alu_wr  = 1'b1;
                            ctrl.alu_sel = ALU_ZERO;
                        end else begin
                            ctrl.div_start = 1'b1;
                            state_next     = S_DIV;
                        end
                    end
                    CMD_POP: begin
                        if (sts.empty) begin
                            ctrl.st = STAT_FEW;
                        end else begin
                            ctrl.pop = 1'b1;
                        end
                    end
                    CMD_CLEAR: begin
                        ctrl.clear = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_MUL: begin
                ctrl.alu_wr  = 1'b1;
                ctrl.alu_sel = ALU_MUL;
                state_next   = S_DONE;
            end
            S_DIV: begin
                // hold until the last quotient bit is in
                if (sts.div_done) begin
                    ctrl.alu_wr  = 1'b1;
                    ctrl.alu_sel = ALU_DIV;
                    state_next   = S_DONE;
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    ctrl.out_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

// ----- hw/rtl/integer_rpn_stack_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer RPN stack ALU
// Bounded LIFO of signed 32-bit integers with add, subtract, multiply and
// divide on the top two entries; one result transaction per command.
//
// Channel  Dir  Handshake           Payload
// s_       in   s_valid / s_ready   s_cmd[2:0], s_push_value[31:0]
// m_       out  m_valid / m_ready   m_popped_value[31:0], m_status[1:0],
//                                   m_entries_held[3:0]
//
// Multiply adds a multiply state before write-back; divide waits in a
// divide state until the divider has its last quotient bit.
// A command that ends in an error status (divide by zero included) or
// carries the unused code goes straight from decode to the output hand-off.
// s_ready is high only while the controller is idle; one command at a time.
// A finished result sits in the output register, so the next command is
// accepted while it waits; a stalled m_ready holds the command after that.
// Synchronous active-low reset empties the stack; stack contents are not
// cleared.
// ----------------------------------------------------------------------------
module integer_rpn_stack_alu
    import rpnalu_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [CMD_W-1:0]         s_cmd,
    input  logic signed [DATA_W-1:0] s_push_value,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_popped_value,
    output logic [STAT_W-1:0]        m_status,
    output logic [HELD_W-1:0]        m_entries_held
);

    ctrl_cmd_t ctrl;
    dp_sts_t   sts;

    rpnalu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctrl    (ctrl)
    );

    rpnalu_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_cmd          (s_cmd),
        .s_push_value   (s_push_value),
        .ctrl           (ctrl),
        .sts            (sts),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_popped_value (m_popped_value),
        .m_status       (m_status),
        .m_entries_held (m_entries_held)
    );

endmodule
